FILE: hw/rtl/sfm_pkg.sv
// shared types and constants for the substring first match core
package sfm_pkg;

    // input opcodes, code 3 is unused and ignored
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2
    } t_opcode;

    localparam int unsigned POS_W = 16;
    localparam logic [POS_W-1:0] NOT_FOUND = 16'hFFFF;
    localparam logic [POS_W-1:0] POS_LIMIT = 16'hFFFE;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic       pat_clear;
        logic       pat_write;
        logic       srch_clear;
        logic       text;
        logic [7:0] data;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/substring_first_match_core.sv
// top level of the substring first match core: cell chain, position tracking, result register
//
//   channel | direction | handshake                 | words
//   input   | in        | i_in_valid / o_in_ready   | i_opcode, i_data_byte, i_is_last
//   output  | out       | o_out_valid / i_out_ready | o_match_position, o_found
//
// one input word per cycle unless the input is stalled; every cell compares its pattern byte in parallel
// and hands its registered partial match bit to the next cell on each text byte.
// the result of a last text byte sits in the output register from the cycle after it is accepted.
// input stalls only while a result waits in the output register and is not taken.
// synchronous active-low reset clears length, search state and cell flags; no clearing pass.
module substring_first_match_core #(
    parameter int unsigned PATTERN_MAX = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_match_position,
    output logic        o_found
);
    import sfm_pkg::*;

    localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       n_len;
    logic [POS_W-1:0]       r_pos;
    logic [POS_W-1:0]       n_pos;
    logic                   r_seen;
    logic                   n_seen;
    logic [POS_W-1:0]       r_first;
    logic [POS_W-1:0]       n_first;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic [POS_W-1:0]       r_out_pos;
    logic                   r_out_found;
    logic [POS_W-1:0]       n_out_pos;
    logic                   n_out_found;
    logic                   w_accept;
    logic                   w_op_clear;
    logic                   w_op_append;
    logic                   w_op_text;
    logic                   w_hit;
    logic [POS_W-1:0]       w_back;
    logic [POS_W-1:0]       w_start;
    t_cell_ctl              w_ctl;
    logic [PATTERN_MAX-1:0] w_wr_sel;
    logic [PATTERN_MAX-1:0] w_pm;
    logic [PATTERN_MAX-1:0] w_pm_step;
    logic [PATTERN_MAX-1:0] w_tail;

    // handshake
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // opcode decode
    always_comb begin
        w_op_clear  = 1'b0;
        w_op_append = 1'b0;
        w_op_text   = 1'b0;
        case (t_opcode'(i_opcode))
            OP_CLEAR:  w_op_clear  = w_accept;
            OP_APPEND: w_op_append = w_accept;
            OP_TEXT:   w_op_text   = w_accept;
            default: ;
        endcase
    end

    // control word broadcast to the cells
    always_comb begin
        w_ctl.pat_clear  = w_op_clear;
        w_ctl.pat_write  = w_op_append && (r_len < LEN_W'(PATTERN_MAX));
        w_ctl.srch_clear = w_op_clear || w_op_append || (w_op_text && i_is_last);
        w_ctl.text       = w_op_text;
        w_ctl.data       = i_data_byte;
    end

    // cell chain
    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
        logic w_prev;
        if (g == 0) begin : g_head
            assign w_prev = 1'b1;
        end else begin : g_link
            assign w_prev = w_pm[g-1];
        end
        assign w_wr_sel[g] = (r_len == LEN_W'(g));
        sfm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_wr_sel  (w_wr_sel[g]),
            .i_pm_prev (w_prev),
            .o_pm      (w_pm[g]),
            .o_pm_step (w_pm_step[g]),
            .o_tail    (w_tail[g])
        );
    end

    // full match at the tail cell and its start position
    assign w_hit   = |(w_pm_step & w_tail);
    assign w_back  = POS_W'(r_len) - POS_W'(1);
    assign w_start = (r_pos >= w_back) ? (r_pos - w_back) : '0;

    // next state of search tracking and result register
    always_comb begin
        n_len       = r_len;
        n_pos       = r_pos;
        n_seen      = r_seen;
        n_first     = r_first;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_pos   = r_out_pos;
        n_out_found = r_out_found;
        if (w_op_clear) begin
            n_len = '0;
        end else if (w_ctl.pat_write) begin
            n_len = r_len + LEN_W'(1);
        end
        if (w_ctl.srch_clear) begin
            n_pos   = '0;
            n_seen  = 1'b0;
            n_first = NOT_FOUND;
        end else if (w_op_text) begin
            if (r_pos < POS_LIMIT) begin
                n_pos = r_pos + POS_W'(1);
            end
            if (!r_seen && w_hit) begin
                n_seen  = 1'b1;
                n_first = w_start;
            end
        end
        if (w_op_text && i_is_last) begin
            n_out_valid = 1'b1;
            if (r_seen) begin
                n_out_pos   = r_first;
                n_out_found = 1'b1;
            end else if (w_hit) begin
                n_out_pos   = w_start;
                n_out_found = 1'b1;
            end else begin
                n_out_pos   = NOT_FOUND;
                n_out_found = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_pos       <= '0;
            r_seen      <= 1'b0;
            r_first     <= NOT_FOUND;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_seen      <= n_seen;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_pos   <= n_out_pos;
        r_out_found <= n_out_found;
    end

    assign o_out_valid      = r_out_valid;
    assign o_match_position = r_out_pos;
    assign o_found          = r_out_found;

    // a found result never carries the not-found code
    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_match_position != NOT_FOUND)
        else $error("found result with not-found position");

    // a miss always reports the not-found code
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_match_position == NOT_FOUND)
        else $error("miss result with a position");

    // at most one cell marks the pattern end
    a_tail_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tail))
        else $error("more than one tail cell");

    // a recorded match needs a nonempty pattern
    a_seen_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> r_len != '0 && r_len <= LEN_W'(PATTERN_MAX))
        else $error("match recorded with bad pattern length");

endmodule

FILE: hw/rtl/sfm_cell.sv
// one pattern byte cell of the shift-and chain
module sfm_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sfm_pkg::t_cell_ctl i_ctl,
    input  logic               i_wr_sel,
    input  logic               i_pm_prev,
    output logic               o_pm,
    output logic               o_pm_step,
    output logic               o_tail
);
    import sfm_pkg::*;

    logic [7:0] r_pat;
    logic       r_used;
    logic       r_tail;
    logic       r_pm;
    logic       n_used;
    logic       n_tail;
    logic       n_pm;

    // partial match extends when the previous cell matched, this cell is in use and its byte is equal
    assign o_pm_step = i_pm_prev & r_used & (r_pat == i_ctl.data);
    assign o_pm      = r_pm;
    assign o_tail    = r_tail;

    // next state of the cell flags
    always_comb begin
        n_used = r_used;
        n_tail = r_tail;
        if (i_ctl.pat_clear) begin
            n_used = 1'b0;
            n_tail = 1'b0;
        end else if (i_ctl.pat_write) begin
            n_tail = i_wr_sel;
            if (i_wr_sel) begin
                n_used = 1'b1;
            end
        end
        n_pm = r_pm;
        if (i_ctl.srch_clear) begin
            n_pm = 1'b0;
        end else if (i_ctl.text) begin
            n_pm = o_pm_step;
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_tail <= 1'b0;
            r_pm   <= 1'b0;
        end else begin
            r_used <= n_used;
            r_tail <= n_tail;
            r_pm   <= n_pm;
        end
    end

    // pattern byte storage
    always_ff @(posedge i_clk) begin
        if (i_ctl.pat_write && i_wr_sel) begin
            r_pat <= i_ctl.data;
        end
    end

endmodule

FILE: test/substring_first_match_checker.sv
// channel monitor, first match predictor and result compare for the substring first match core
module substring_first_match_checker #(
    parameter int unsigned PATTERN_MAX = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic [1:0]                i_opcode,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_is_last,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [sfm_pkg::POS_W-1:0] i_match_position,
    input  logic                      i_found,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfm_pkg::*;

    localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
    } t_match_report;

    // reports owed by the core, oldest first
    t_match_report reports_due[$];

    // mirrored pattern and search state
    logic [7:0]             pat_bytes [PATTERN_MAX];
    logic [LEN_W-1:0]       pat_len;
    logic [PATTERN_MAX-1:0] partial_hits;
    logic [POS_W-1:0]       text_pos;
    logic [POS_W-1:0]       first_hit;
    logic                   hit_seen;
    int                     mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    function automatic void restart_search();
        partial_hits = '0;
        text_pos     = '0;
        hit_seen     = 1'b0;
        first_hit    = NOT_FOUND;
    endfunction

    // advance the mirrored search by one accepted input word
    function automatic void search_step(logic [1:0] op, logic [7:0] data, logic last);
        logic [PATTERN_MAX-1:0] byte_eq;
        t_match_report          report;
        int                     back;
        case (op)
            OP_CLEAR: begin
                pat_len = '0;
                restart_search();
            end
            OP_APPEND: begin
                // bytes past the pattern capacity are dropped
                if (pat_len < PATTERN_MAX) begin
                    pat_bytes[pat_len] = data;
                    pat_len++;
                end
                restart_search();
            end
            OP_TEXT: begin
                if (pat_len != 0) begin
                    byte_eq = '0;
                    for (int i = 0; i < PATTERN_MAX; i++) begin
                        if (i < pat_len && pat_bytes[i] == data) begin
                            byte_eq[i] = 1'b1;
                        end
                    end
                    partial_hits = ((partial_hits << 1) | 1'b1) & byte_eq;
                    // only the earliest full match is kept
                    if (!hit_seen && partial_hits[pat_len-1]) begin
                        back      = pat_len - 1;
                        hit_seen  = 1'b1;
                        first_hit = (text_pos >= back) ? POS_W'(text_pos - back) : '0;
                    end
                end
                // position saturates one below the not-found code
                if (text_pos < POS_LIMIT) begin
                    text_pos++;
                end
                if (last) begin
                    report.position = hit_seen ? first_hit : NOT_FOUND;
                    report.found    = hit_seen;
                    reports_due.push_back(report);
                    restart_search();
                end
            end
            default: begin
            end
        endcase
    endfunction

    // compare accepted results, then fold in the accepted input word
    always @(posedge i_clk) begin : monitor
        t_match_report due;
        if (!i_rst_n) begin
            pat_len = '0;
            restart_search();
            reports_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (reports_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: unexpected result word: position %0d found %0b",
                                 $realtime, i_match_position, i_found);
                    end
                end else begin
                    due = reports_due.pop_front();
                    if (i_match_position !== due.position || i_found !== due.found) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display({"%0t: result mismatch: expected position %0d ",
                                      "found %0b, got position %0d found %0b"},
                                     $realtime, due.position, due.found,
                                     i_match_position, i_found);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                search_step(i_opcode, i_data_byte, i_is_last);
            end
        end
        o_pending <= reports_due.size();
    end

endmodule

FILE: test/substring_first_match_core_tb.sv
// stimulus and verdict for the substring first match core
module substring_first_match_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfm_pkg::*;

    localparam int unsigned PATTERN_MAX    = 16;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam int          RANDOM_WORDS   = 1800;
    localparam int          IDLE_MAX       = 18;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [1:0]       i_opcode = OP_CLEAR;
    logic [7:0]       i_data_byte = 8'h00;
    logic             i_is_last = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [POS_W-1:0] o_match_position;
    logic             o_found;

    int tx_idle_max = 0;
    int rx_idle_max = 0;
    int rx_stall_left = 0;
    int words_sent = 0;
    int fail_count;
    int results_due;

    substring_first_match_core #(
        .PATTERN_MAX(PATTERN_MAX)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_data_byte     (i_data_byte),
        .i_is_last       (i_is_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_match_position(o_match_position),
        .o_found         (o_found)
    );

    substring_first_match_checker #(
        .PATTERN_MAX(PATTERN_MAX)
    ) match_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_data_byte     (i_data_byte),
        .i_is_last       (i_is_last),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_match_position(o_match_position),
        .i_found         (o_found),
        .o_fail_count    (fail_count),
        .o_pending       (results_due)
    );

    always #10 i_clk = ~i_clk;

    // watchdog
    initial begin
        #20ms;
        $display("[substring_first_match_core] ERROR");
        $finish;
    end

    // result side: random stall drawn after every taken word
    always @(posedge i_clk) begin : rx_ready_gen
        int stall_draw;
        if (!i_rst_n) begin
            i_out_ready   <= 1'b0;
            rx_stall_left <= 0;
        end else if (o_out_valid && i_out_ready) begin
            stall_draw     = $urandom_range(0, rx_idle_max);
            rx_stall_left <= stall_draw;
            i_out_ready   <= (stall_draw == 0);
        end else if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
            i_out_ready   <= (rx_stall_left == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // present one word after a random gap and hold it until taken
    task automatic send_word(input logic [1:0] op, input logic [7:0] data, input logic last);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_data_byte <= data;
        i_is_last   <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (op != OP_UNUSED) begin
            words_sent++;
        end
    endtask

    // drop valid and hold off until every owed result has been taken
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_due != 0);
    endtask

    function automatic int pick_idle();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 2;
            2:       return IDLE_MAX;
            default: return $urandom_range(0, IDLE_MAX);
        endcase
    endfunction

    function automatic logic [7:0] alphabet_byte(int lo, int span);
        return 8'(lo + $urandom_range(0, span - 1));
    endfunction

    // one pattern load plus one text, often carrying a planted copy of the pattern
    task automatic run_search_sequence();
        logic [7:0] pat [PATTERN_MAX + 4];
        logic [7:0] text_byte;
        int         plen;
        int         tlen;
        int         plant_at;
        int         alpha_lo;
        int         alpha_span;
        tx_idle_max = pick_idle();
        rx_idle_max = pick_idle();
        alpha_lo    = $urandom_range(0, 255);
        case ($urandom_range(0, 2))
            0:       alpha_span = 2;
            1:       alpha_span = 4;
            default: alpha_span = 256;
        endcase
        case ($urandom_range(0, 9))
            0:       plen = 0;
            1:       plen = $urandom_range(PATTERN_MAX - 1, PATTERN_MAX + 3);
            default: plen = $urandom_range(1, 4);
        endcase
        // a missing clear lets the new bytes extend the old pattern
        if ($urandom_range(0, 9) != 0) begin
            send_word(OP_CLEAR, 8'($urandom), ($urandom_range(0, 7) == 0));
        end
        for (int i = 0; i < plen; i++) begin
            pat[i] = alphabet_byte(alpha_lo, alpha_span);
            send_word(OP_APPEND, pat[i], ($urandom_range(0, 7) == 0));
        end
        tlen = $urandom_range(1, ((plen > 4) ? plen : 4) + 20);
        if (plen > 0 && plen <= PATTERN_MAX && tlen >= plen && $urandom_range(0, 2) != 0) begin
            plant_at = $urandom_range(0, tlen - plen);
        end else begin
            plant_at = -1;
        end
        for (int i = 0; i < tlen; i++) begin
            // occasional noise: unused code, pattern edits mid-text
            if ($urandom_range(0, 39) == 0) begin
                send_word(OP_UNUSED, 8'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 79) == 0) begin
                send_word(($urandom_range(0, 1) == 0) ? OP_CLEAR : OP_APPEND,
                          alphabet_byte(alpha_lo, alpha_span), 1'($urandom));
            end
            if (plant_at >= 0 && i >= plant_at && i < plant_at + plen) begin
                text_byte = pat[i - plant_at];
            end else begin
                text_byte = alphabet_byte(alpha_lo, alpha_span);
            end
            send_word(OP_TEXT, text_byte,
                      (i == tlen - 1) || ($urandom_range(0, 59) == 0));
        end
    endtask

    initial begin
        bit drained;
        drained = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words
        tx_idle_max = 3;
        rx_idle_max = IDLE_MAX;
        // empty pattern gives not found
        send_word(OP_TEXT, 8'h41, 1'b1);
        // unused code and last flag on pattern words are ignored
        send_word(OP_UNUSED, 8'hFF, 1'b1);
        send_word(OP_CLEAR, 8'hFF, 1'b1);
        send_word(OP_APPEND, 8'h00, 1'b1);
        send_word(OP_APPEND, 8'hFF, 1'b0);
        // match at the very start
        send_word(OP_TEXT, 8'h00, 1'b0);
        send_word(OP_TEXT, 8'hFF, 1'b1);
        // text shorter than the pattern
        send_word(OP_TEXT, 8'h00, 1'b1);
        // two matches, the earlier one is reported
        send_word(OP_TEXT, 8'hFF, 1'b0);
        send_word(OP_TEXT, 8'h00, 1'b0);
        send_word(OP_TEXT, 8'hFF, 1'b0);
        send_word(OP_TEXT, 8'h00, 1'b0);
        send_word(OP_TEXT, 8'hFF, 1'b1);
        // pattern edit in the middle of a search restarts it
        send_word(OP_TEXT, 8'h00, 1'b0);
        send_word(OP_APPEND, 8'h00, 1'b0);
        send_word(OP_TEXT, 8'hFF, 1'b0);
        send_word(OP_TEXT, 8'h00, 1'b0);
        send_word(OP_TEXT, 8'hFF, 1'b0);
        send_word(OP_TEXT, 8'h00, 1'b1);

        // random searches, with one full drain halfway
        while (words_sent < RANDOM_WORDS) begin
            run_search_sequence();
            if (!drained && words_sent >= RANDOM_WORDS / 2) begin
                wait_for_results();
                drained = 1'b1;
            end
        end

        // drain, then a quiet stretch to catch stray results
        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && results_due == 0) begin
            $display("[substring_first_match_core] OK");
        end else begin
            $display("[substring_first_match_core] ERROR");
        end
        $finish;
    end

endmodule

FILE: substring_first_match_core.f
hw/rtl/sfm_pkg.sv
hw/rtl/sfm_cell.sv
hw/rtl/substring_first_match_core.sv
test/substring_first_match_checker.sv
test/substring_first_match_core_tb.sv
